>>> rtl/core/lav_pkg.sv
// shared constants and latency helper for the look-at view matrix pipeline
// no dependencies; used by every module under rtl/core except lav_delay
package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int AXIS_W        = 18;
  localparam int IN_W          = 288;
  localparam int OUT_W         = 264;

  // vectors are scaled so the largest magnitude has its top bit here
  localparam int NORM_TOP      = 29;
  localparam int SCALE_W       = NORM_TOP + 1;
  localparam int SUM_W         = 2 * SCALE_W + 2;
  localparam int LEN_W         = SCALE_W + 1;
  localparam int SQRT_STAGES   = 31;
  localparam int NORM_FRONT    = 6;

  // front stages, square root, divider (prep plus one stage per quotient bit), sign stage
  function automatic int norm_lat(input int frac);
    return NORM_FRONT + SQRT_STAGES + frac + 3;
  endfunction

endpackage

>>> rtl/core/lookat_view_matrix.sv
// look-at view matrix: throughput one camera transaction per cycle while the skid entry
// is empty; the pipeline depth comes from two square root pipelines (31 stages each)
// and two dividers (FRAC_BITS+2 stages each)
// a two-entry output (register plus skid) lets input continue while one result waits
// asynchronous active-low reset clears all valid bits; data registers are not reset
module lookat_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (32 bits each)
  input  logic [lav_pkg::IN_W-1:0]   s_axis_tdata_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // right_x/y/z, upward_x/y/z, back_x/y/z (18 bits each), shift_right, shift_upward,
  // shift_back (32 bits each), 6 zero bits
  output logic [lav_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  localparam int F   = FRAC_BITS;
  localparam int CDW = lav_pkg::COORD_W;
  localparam int AW  = F + 2;
  localparam int LAT = lav_pkg::norm_lat(F);
  localparam int XPW = CDW + AW;
  localparam int CW  = XPW + 1;
  localparam int YPW = 2 * AW;
  localparam int YDW = YPW + 1;
  localparam int ZPW = CDW + AW;
  localparam int ZSW = ZPW + 2;
  localparam int PAD = lav_pkg::OUT_W - 9 * lav_pkg::AXIS_W - 3 * CDW;

  function automatic logic [lav_pkg::AXIS_W-1:0] fld(input logic signed [AW-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[lav_pkg::AXIS_W-1:0];
  endfunction

  logic en;

  // input stage
  logic signed [CDW-1:0] eye_in [3];
  logic signed [CDW-1:0] tgt_in [3];
  logic signed [CDW-1:0] up_in  [3];
  logic signed [CDW-1:0] eye1_q [3];
  logic signed [CDW-1:0] up1_q  [3];
  logic signed [CDW:0]   d1_q   [3];
  logic                  v1_q;

  // first normalize and cross product
  logic                  va;
  logic signed [AW-1:0]  bz [3];
  logic [3*CDW-1:0]      up_a_flat;
  logic signed [CDW-1:0] up_a [3];
  logic signed [XPW-1:0] px_d [6];
  logic signed [XPW-1:0] px_q [6];
  logic signed [CW-1:0]  c_q [3];
  logic                  vx1_q, vx2_q;

  // second normalize and upward axis
  logic                  vb;
  logic signed [AW-1:0]  rx [3];
  logic [3*AW-1:0]       bzb_flat;
  logic signed [AW-1:0]  bzb [3];
  logic signed [YPW-1:0] py_q [6];
  logic signed [YDW-1:0] yd_q [3];
  logic [YDW-1:0]        yq_q [3];
  logic [2:0]            ys_q;
  logic signed [AW-1:0]  uy_q [3];
  logic                  vy1_q, vy2_q, vy3_q, vy4_q;

  // translations
  logic [3*CDW-1:0]      eye_y_flat;
  logic signed [CDW-1:0] eye_y [3];
  logic [3*AW-1:0]       rxy_flat, bzy_flat;
  logic signed [AW-1:0]  ax_y [3][3];
  logic signed [ZPW-1:0] pz_q [3][3];
  logic signed [ZSW-1:0] zs_q [3];
  logic [ZSW-1:0]        zq_q [3];
  logic [2:0]            zsg_q;
  logic [CDW-1:0]        tr_q [3];
  logic                  vz1_q, vz2_q, vz3_q, vz4_q;
  logic [3*AW-1:0]       rxz_flat, uyz_flat, bzz_flat;

  // output register and skid
  logic                     pv;
  logic [lav_pkg::OUT_W-1:0] pdata;
  logic                     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic [lav_pkg::OUT_W-1:0] out_data_q, skid_data_q;
  logic                     take, out_from_skid, out_from_pipe, skid_load;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_in[i] = s_axis_tdata_i[CDW*i +: CDW];
      tgt_in[i] = s_axis_tdata_i[CDW*(3+i) +: CDW];
      up_in[i]  = s_axis_tdata_i[CDW*(6+i) +: CDW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eye1_q[i] <= eye_in[i];
        up1_q[i]  <= up_in[i];
        d1_q[i]   <= (CDW+1)'(eye_in[i]) - (CDW+1)'(tgt_in[i]);
      end
    end
  end

  lav_norm #(
    .IW       (CDW + 1),
    .FRAC_BITS(F)
  ) u_norm_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .vec_i   (d1_q),
    .valid_o (va),
    .axis_o  (bz)
  );

  lav_delay #(.W(3*CDW), .DEPTH(LAT)) u_dly_up (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({up1_q[2], up1_q[1], up1_q[0]}),
    .q_o   (up_a_flat)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) up_a[i] = up_a_flat[CDW*i +: CDW];
    // up cross back
    px_d[0] = XPW'(up_a[1]) * XPW'(bz[2]);
    px_d[1] = XPW'(up_a[2]) * XPW'(bz[1]);
    px_d[2] = XPW'(up_a[2]) * XPW'(bz[0]);
    px_d[3] = XPW'(up_a[0]) * XPW'(bz[2]);
    px_d[4] = XPW'(up_a[0]) * XPW'(bz[1]);
    px_d[5] = XPW'(up_a[1]) * XPW'(bz[0]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 6; k++) px_q[k] <= px_d[k];
      for (int i = 0; i < 3; i++) c_q[i] <= CW'(px_q[2*i]) - CW'(px_q[2*i+1]);
    end
  end

  lav_norm #(
    .IW       (CW),
    .FRAC_BITS(F)
  ) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vx2_q),
    .vec_i   (c_q),
    .valid_o (vb),
    .axis_o  (rx)
  );

  lav_delay #(.W(3*AW), .DEPTH(LAT + 2)) u_dly_bz (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({bz[2], bz[1], bz[0]}),
    .q_o   (bzb_flat)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) bzb[i] = bzb_flat[AW*i +: AW];
  end

  // back cross right, rounded half away from zero, clamped to one
  always_ff @(posedge clk_i) begin
    logic [YDW-1:0] mag;
    logic [YDW-1:0] qc;
    if (en) begin
      py_q[0] <= YPW'(bzb[1]) * YPW'(rx[2]);
      py_q[1] <= YPW'(bzb[2]) * YPW'(rx[1]);
      py_q[2] <= YPW'(bzb[2]) * YPW'(rx[0]);
      py_q[3] <= YPW'(bzb[0]) * YPW'(rx[2]);
      py_q[4] <= YPW'(bzb[0]) * YPW'(rx[1]);
      py_q[5] <= YPW'(bzb[1]) * YPW'(rx[0]);
      for (int i = 0; i < 3; i++) begin
        yd_q[i] <= YDW'(py_q[2*i]) - YDW'(py_q[2*i+1]);
        mag     = yd_q[i][YDW-1] ? YDW'(-yd_q[i]) : YDW'(yd_q[i]);
        yq_q[i] <= (mag + (YDW'(1) << (F - 1))) >> F;
        ys_q[i] <= yd_q[i][YDW-1];
        qc      = (yq_q[i] > (YDW'(1) << F)) ? (YDW'(1) << F) : yq_q[i];
        uy_q[i] <= ys_q[i] ? -AW'(qc) : AW'(qc);
      end
    end
  end

  lav_delay #(.W(3*CDW), .DEPTH(2*LAT + 6)) u_dly_eye (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({eye1_q[2], eye1_q[1], eye1_q[0]}),
    .q_o   (eye_y_flat)
  );

  lav_delay #(.W(3*AW), .DEPTH(4)) u_dly_rx (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({rx[2], rx[1], rx[0]}),
    .q_o   (rxy_flat)
  );

  lav_delay #(.W(3*AW), .DEPTH(4)) u_dly_bzy (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (bzb_flat),
    .q_o   (bzy_flat)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      eye_y[i]    = eye_y_flat[CDW*i +: CDW];
      ax_y[0][i]  = rxy_flat[AW*i +: AW];
      ax_y[1][i]  = uy_q[i];
      ax_y[2][i]  = bzy_flat[AW*i +: AW];
    end
  end

  // negated dot with the eye, rounded half away from zero, saturated to 32 bits
  always_ff @(posedge clk_i) begin
    logic [ZSW-1:0] mag;
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        for (int i = 0; i < 3; i++) pz_q[a][i] <= ZPW'(ax_y[a][i]) * ZPW'(eye_y[i]);
        zs_q[a]  <= ZSW'(pz_q[a][0]) + ZSW'(pz_q[a][1]) + ZSW'(pz_q[a][2]);
        mag      = zs_q[a][ZSW-1] ? ZSW'(-zs_q[a]) : ZSW'(zs_q[a]);
        zq_q[a]  <= (mag + (ZSW'(1) << (F - 1))) >> F;
        zsg_q[a] <= zs_q[a][ZSW-1];
        if (zsg_q[a]) begin
          tr_q[a] <= (zq_q[a] > ZSW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : zq_q[a][CDW-1:0];
        end else begin
          tr_q[a] <= (zq_q[a] > ZSW'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                             : -zq_q[a][CDW-1:0];
        end
      end
    end
  end

  lav_delay #(.W(3*AW), .DEPTH(4)) u_dly_rxz (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (rxy_flat),
    .q_o   (rxz_flat)
  );

  lav_delay #(.W(3*AW), .DEPTH(4)) u_dly_uyz (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({uy_q[2], uy_q[1], uy_q[0]}),
    .q_o   (uyz_flat)
  );

  lav_delay #(.W(3*AW), .DEPTH(4)) u_dly_bzz (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (bzy_flat),
    .q_o   (bzz_flat)
  );

  assign pv    = vz4_q;
  assign pdata = {PAD'(0), tr_q[2], tr_q[1], tr_q[0],
                  fld(bzz_flat[2*AW +: AW]), fld(bzz_flat[AW +: AW]), fld(bzz_flat[0 +: AW]),
                  fld(uyz_flat[2*AW +: AW]), fld(uyz_flat[AW +: AW]), fld(uyz_flat[0 +: AW]),
                  fld(rxz_flat[2*AW +: AW]), fld(rxz_flat[AW +: AW]), fld(rxz_flat[0 +: AW])};

  // the whole pipeline advances unless the skid entry is occupied
  assign en   = !skid_valid_q;
  assign take = out_valid_q && m_axis_tready_i;

  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    out_from_skid = 1'b0;
    out_from_pipe = 1'b0;
    skid_load     = 1'b0;
    if (skid_valid_q) begin
      if (take || !out_valid_q) begin
        out_from_skid = 1'b1;
        out_valid_d   = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (pv) begin
      if (!out_valid_q || take) begin
        out_from_pipe = 1'b1;
        out_valid_d   = 1'b1;
      end else begin
        skid_load    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q         <= 1'b0;
      vx1_q        <= 1'b0;
      vx2_q        <= 1'b0;
      vy1_q        <= 1'b0;
      vy2_q        <= 1'b0;
      vy3_q        <= 1'b0;
      vy4_q        <= 1'b0;
      vz1_q        <= 1'b0;
      vz2_q        <= 1'b0;
      vz3_q        <= 1'b0;
      vz4_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v1_q  <= s_axis_tvalid_i;
        vx1_q <= va;
        vx2_q <= vx1_q;
        vy1_q <= vb;
        vy2_q <= vy1_q;
        vy3_q <= vy2_q;
        vy4_q <= vy3_q;
        vz1_q <= vy4_q;
        vz2_q <= vz1_q;
        vz3_q <= vz2_q;
        vz4_q <= vz3_q;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_data_q <= skid_data_q;
    end else if (out_from_pipe) begin
      out_data_q <= pdata;
    end
    if (skid_load) begin
      skid_data_q <= pdata;
    end
  end

  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held without a pending output");

  a_stall_fills_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i && pv && !skid_valid_q |=> skid_valid_q)
    else $error("finished result not captured while output stalled");

  a_skid_drains : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && m_axis_tready_i |=> !skid_valid_q)
    else $error("skid entry not drained after output transaction");

endmodule

>>> rtl/core/lav_delay.sv
// enable-gated shift line that keeps side data aligned with the pipeline
// depends on nothing
module lav_delay #(
  parameter int W     = 32,
  parameter int DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] dl_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dl_q[0] <= d_i;
      for (int k = 1; k < DEPTH; k++) begin
        dl_q[k] <= dl_q[k-1];
      end
    end
  end

  assign q_o = dl_q[DEPTH-1];

endmodule

>>> rtl/core/lav_isqrt.sv
// pipelined integer square root, one result bit per stage, with pass-along data
// depends on lav_pkg
module lav_isqrt #(
  parameter int PW = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [lav_pkg::SUM_W-1:0] sum_i,
  input  logic [PW-1:0]             pass_i,
  output logic                      valid_o,
  output logic [lav_pkg::LEN_W-1:0] len_o,
  output logic [PW-1:0]             pass_o
);

  localparam int NS = lav_pkg::SQRT_STAGES;
  localparam int NW = lav_pkg::SUM_W;
  localparam int RW = lav_pkg::SUM_W + 1;

  logic          v_q [NS];
  logic          v_d [NS];
  logic [NW-1:0] n_q [NS];
  logic [NW-1:0] n_d [NS];
  logic [RW-1:0] r_q [NS];
  logic [RW-1:0] r_d [NS];
  logic [PW-1:0] p_q [NS];
  logic [PW-1:0] p_d [NS];

  always_comb begin
    logic [NW-1:0] n_in;
    logic [RW-1:0] r_in;
    logic [RW-1:0] bit_v;
    logic [RW-1:0] trial;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        n_in   = sum_i;
        r_in   = '0;
        v_d[s] = valid_i;
        p_d[s] = pass_i;
      end else begin
        n_in   = n_q[s-1];
        r_in   = r_q[s-1];
        v_d[s] = v_q[s-1];
        p_d[s] = p_q[s-1];
      end
      bit_v = RW'(1) << (2 * (NS - 1 - s));
      trial = r_in + bit_v;
      if ({1'b0, n_in} >= trial) begin
        n_d[s] = n_in - trial[NW-1:0];
        r_d[s] = (r_in >> 1) + bit_v;
      end else begin
        n_d[s] = n_in;
        r_d[s] = r_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NS; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < NS; s++) v_q[s] <= v_d[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NS; s++) begin
        n_q[s] <= n_d[s];
        r_q[s] <= r_d[s];
        p_q[s] <= p_d[s];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign len_o   = r_q[NS-1][lav_pkg::LEN_W-1:0];
  assign pass_o  = p_q[NS-1];

endmodule

>>> rtl/core/lav_div.sv
// pipelined restoring divider for three components over one shared length
// computes (m * 2^frac + len/2) / len, one quotient bit per stage; depends on lav_pkg
module lav_div #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF,
  parameter int PW        = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [lav_pkg::LEN_W-1:0]   len_i,
  input  logic [lav_pkg::SCALE_W-1:0] m_i [3],
  input  logic [PW-1:0]               pass_i,
  output logic                        valid_o,
  output logic [FRAC_BITS:0]          q_o [3],
  output logic [PW-1:0]               pass_o
);

  localparam int QW  = FRAC_BITS + 1;
  localparam int NST = QW + 1;
  localparam int RW  = lav_pkg::LEN_W;
  localparam int NW  = lav_pkg::SCALE_W + FRAC_BITS + 1;

  logic          v_q   [NST];
  logic          v_d   [NST];
  logic [RW-1:0] len_q [NST];
  logic [RW-1:0] len_d [NST];
  logic [PW-1:0] p_q   [NST];
  logic [PW-1:0] p_d   [NST];
  logic [RW-1:0] rem_q [NST][3];
  logic [RW-1:0] rem_d [NST][3];
  logic [QW-1:0] low_q [NST][3];
  logic [QW-1:0] low_d [NST][3];
  logic [QW-1:0] quo_q [NST][3];
  logic [QW-1:0] quo_d [NST][3];

  always_comb begin
    logic [NW-1:0] nn;
    logic [RW:0]   t;
    logic          ge;
    v_d[0]   = valid_i;
    len_d[0] = len_i;
    p_d[0]   = pass_i;
    for (int i = 0; i < 3; i++) begin
      // rounding term added up front, high part is already below len
      nn          = NW'({m_i[i], {FRAC_BITS{1'b0}}}) + NW'(len_i >> 1);
      rem_d[0][i] = RW'(nn[NW-1:QW]);
      low_d[0][i] = nn[QW-1:0];
      quo_d[0][i] = '0;
    end
    for (int s = 1; s < NST; s++) begin
      v_d[s]   = v_q[s-1];
      len_d[s] = len_q[s-1];
      p_d[s]   = p_q[s-1];
      for (int i = 0; i < 3; i++) begin
        t  = {rem_q[s-1][i], low_q[s-1][i][QW-1]};
        ge = t >= {1'b0, len_q[s-1]};
        rem_d[s][i] = ge ? RW'(t - {1'b0, len_q[s-1]}) : RW'(t);
        low_d[s][i] = low_q[s-1][i] << 1;
        quo_d[s][i] = {quo_q[s-1][i][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < NST; s++) v_q[s] <= v_d[s];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        len_q[s] <= len_d[s];
        p_q[s]   <= p_d[s];
        for (int i = 0; i < 3; i++) begin
          rem_q[s][i] <= rem_d[s][i];
          low_q[s][i] <= low_d[s][i];
          quo_q[s][i] <= quo_d[s][i];
        end
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign pass_o  = p_q[NST-1];
  always_comb begin
    for (int i = 0; i < 3; i++) q_o[i] = quo_q[NST-1][i];
  end

endmodule

>>> rtl/core/lav_norm.sv
// pipelined 3-vector normalizer: scale to a fixed top bit, sum of squares,
// square root, per-component divide and sign restore; depends on lav_pkg, lav_isqrt, lav_div
module lav_norm #(
  parameter int IW        = 33,
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [IW-1:0]        vec_i [3],
  output logic                        valid_o,
  output logic signed [FRAC_BITS+1:0] axis_o [3]
);

  localparam int AW     = FRAC_BITS + 2;
  localparam int QW     = FRAC_BITS + 1;
  localparam int SW     = lav_pkg::SCALE_W;
  localparam int NCH    = (IW + 7) / 8;
  localparam int PADW   = NCH * 8;
  localparam int TW     = $clog2(PADW);
  localparam int PASS_W = 4 + 3 * SW;

  logic          v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, vo_q;
  logic [IW-1:0] mag_d [3];
  logic [IW-1:0] or_d;
  logic [IW-1:0] m1_q [3];
  logic [IW-1:0] m2_q [3];
  logic [IW-1:0] m3_q [3];
  logic [IW-1:0] or_q;
  logic [2:0]    s1_q, s2_q, s3_q, s4_q, s5_q, s6_q;
  logic [NCH-1:0] nz_d, nz_q;
  logic [2:0]    pos_d [NCH];
  logic [2:0]    pos_q [NCH];
  logic [TW-1:0] top_d, top_q;
  logic          z_d, z3_q, z4_q, z5_q, z6_q;
  logic [SW-1:0] ms_d  [3];
  logic [SW-1:0] ms4_q [3];
  logic [SW-1:0] ms5_q [3];
  logic [SW-1:0] ms6_q [3];
  logic [2*SW-1:0] sq_d [3];
  logic [2*SW-1:0] sq_q [3];
  logic [lav_pkg::SUM_W-1:0] sum_d, sum_q;

  logic                      sq_valid;
  logic [lav_pkg::LEN_W-1:0] len;
  logic [PASS_W-1:0]         sq_pass;
  logic [SW-1:0]             dv_m [3];
  logic                      dv_valid;
  logic [QW-1:0]             dv_q [3];
  logic [3:0]                dv_pass;
  logic signed [AW-1:0]      axis_q [3];

  // magnitudes; the top bit of the or is the top bit of the largest one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = vec_i[i][IW-1] ? IW'(-vec_i[i]) : IW'(vec_i[i]);
    end
    or_d = mag_d[0] | mag_d[1] | mag_d[2];
  end

  // leading one per byte
  always_comb begin
    logic [PADW-1:0] orp;
    orp = PADW'(or_q);
    for (int c = 0; c < NCH; c++) begin
      nz_d[c]  = |orp[c*8 +: 8];
      pos_d[c] = '0;
      for (int b = 0; b < 8; b++) begin
        if (orp[c*8 + b]) pos_d[c] = 3'(b);
      end
    end
  end

  always_comb begin
    top_d = '0;
    for (int c = 0; c < NCH; c++) begin
      if (nz_q[c]) top_d = {(TW-3)'(c), pos_q[c]};
    end
    z_d = ~|nz_q;
  end

  // scale so the top bit lands at NORM_TOP, truncating on a right shift
  always_comb begin
    logic          dn;
    logic [TW-1:0] sh;
    dn = top_q > TW'(lav_pkg::NORM_TOP);
    sh = dn ? top_q - TW'(lav_pkg::NORM_TOP) : TW'(lav_pkg::NORM_TOP) - top_q;
    for (int i = 0; i < 3; i++) begin
      ms_d[i] = dn ? SW'(m3_q[i] >> sh) : SW'(m3_q[i]) << sh;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_d[i] = (2*SW)'(ms4_q[i]) * (2*SW)'(ms4_q[i]);
    end
    sum_d = lav_pkg::SUM_W'(sq_q[0]) + lav_pkg::SUM_W'(sq_q[1]) + lav_pkg::SUM_W'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      vo_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      or_q  <= or_d;
      nz_q  <= nz_d;
      top_q <= top_d;
      z3_q  <= z_d;
      z4_q  <= z3_q;
      z5_q  <= z4_q;
      z6_q  <= z5_q;
      s1_q  <= {vec_i[2][IW-1], vec_i[1][IW-1], vec_i[0][IW-1]};
      s2_q  <= s1_q;
      s3_q  <= s2_q;
      s4_q  <= s3_q;
      s5_q  <= s4_q;
      s6_q  <= s5_q;
      sum_q <= sum_d;
      for (int c = 0; c < NCH; c++) pos_q[c] <= pos_d[c];
      for (int i = 0; i < 3; i++) begin
        m1_q[i]   <= mag_d[i];
        m2_q[i]   <= m1_q[i];
        m3_q[i]   <= m2_q[i];
        ms4_q[i]  <= ms_d[i];
        ms5_q[i]  <= ms4_q[i];
        ms6_q[i]  <= ms5_q[i];
        sq_q[i]   <= sq_d[i];
        // a zero vector stays zero
        if (dv_pass[3]) begin
          axis_q[i] <= '0;
        end else if (dv_pass[i]) begin
          axis_q[i] <= -AW'(dv_q[i]);
        end else begin
          axis_q[i] <= AW'(dv_q[i]);
        end
      end
    end
  end

  lav_isqrt #(
    .PW(PASS_W)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (v6_q),
    .sum_i   (sum_q),
    .pass_i  ({z6_q, s6_q, ms6_q[2], ms6_q[1], ms6_q[0]}),
    .valid_o (sq_valid),
    .len_o   (len),
    .pass_o  (sq_pass)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) dv_m[i] = sq_pass[i*SW +: SW];
  end

  lav_div #(
    .FRAC_BITS(FRAC_BITS),
    .PW       (4)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (sq_valid),
    .len_i   (len),
    .m_i     (dv_m),
    .pass_i  (sq_pass[PASS_W-1 -: 4]),
    .valid_o (dv_valid),
    .q_o     (dv_q),
    .pass_o  (dv_pass)
  );

  assign valid_o = vo_q;
  always_comb begin
    for (int i = 0; i < 3; i++) axis_o[i] = axis_q[i];
  end

endmodule
